### sv/pru_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the pixel replicating upscaler
package pru_pkg;

  localparam int PixW    = 24;
  localparam int WidthW  = 13;
  localparam int ScaleW  = 5;
  localparam int ApbW    = 32;
  localparam int AddrW   = 3;

  // register indexes
  localparam logic REG_SOURCE_WIDTH = 1'b0;
  localparam logic REG_SCALE_FACTOR = 1'b1;

  // input item kinds
  localparam logic KIND_SOURCE = 1'b0;
  localparam logic KIND_REPLAY = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       is_padding;
    logic       row_end;
    logic       error;
    logic       last;
  } out_item_t;

  // one item's work handed to the beat generator
  typedef struct packed {
    pixel_t pixel;
    logic   ends;
    logic   err;
  } job_t;

endpackage

### sv/pru_line_store.sv
`timescale 1ns / 1ps
// line store: one write port, one registered read port
module pru_line_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  pru_pkg::pixel_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output pru_pkg::pixel_t rdata
);
  import pru_pkg::*;

  pixel_t mem [DEPTH];
  pixel_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/pru_emitter.sv
`timescale 1ns / 1ps
// beat generator: repeats one pixel, appends row padding, holds the output beat
module pru_emitter #(
  parameter int MAX_SCALE = 16,
  parameter int SCW       = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  pru_pkg::job_t       job,
  input  logic [SCW-1:0]      scale,
  input  logic [1:0]          pad,
  output logic                out_valid,
  input  logic                out_ready,
  output pru_pkg::out_item_t  out_data
);
  import pru_pkg::*;

  localparam int TW = $clog2(MAX_SCALE + 3);

  logic           busy_r, busy_nxt;
  logic [TW-1:0]  idx_r, idx_nxt;
  logic [TW-1:0]  last_idx_r;
  logic [SCW-1:0] scale_r;
  job_t           job_r;

  logic           last_beat;
  logic           load;
  logic           is_pad;
  logic [TW-1:0]  total;

  assign last_beat = (idx_r == last_idx_r);
  assign job_ready = !busy_r || (out_ready && last_beat);
  assign load      = job_valid && job_ready;

  always_comb begin
    if (job.err) begin
      total = TW'(1);
    end else if (job.ends) begin
      total = TW'(scale) + TW'(pad);
    end else begin
      total = TW'(scale);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (busy_r && out_ready) begin
      if (last_beat) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // job payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      job_r      <= job;
      last_idx_r <= total - TW'(1);
      scale_r    <= job.err ? SCW'(1) : scale;
    end
  end

  assign is_pad    = (idx_r >= TW'(scale_r));
  assign out_valid = busy_r;

  always_comb begin
    out_data            = '0;
    out_data.out_blue   = is_pad ? 8'd0 : job_r.pixel.blue;
    out_data.out_green  = is_pad ? 8'd0 : job_r.pixel.green;
    out_data.out_red    = is_pad ? 8'd0 : job_r.pixel.red;
    out_data.is_padding = is_pad;
    out_data.row_end    = job_r.ends && last_beat;
    out_data.error      = job_r.err;
    out_data.last       = last_beat;
  end

endmodule

### sv/pixel_replicating_upscaler.sv
`timescale 1ns / 1ps
// nearest-neighbour integer upscaler: line store, row control and beat generator
// flow: an accepted input item is registered in the accepted-item stage and is
// loaded into the beat generator once it is ready, which then offers the result beats
// throughput: one result beat per cycle while out_ready is high; an item gives scale
// beats (plus up to three padding beats at a row end), one beat for a replay error,
// set by the single output beat per cycle of the beat generator
// reset: synchronous active-low; registers return to width 1 and scale 1, columns
// and row-ready clear; the line store is not cleared and needs no clearing pass
module pixel_replicating_upscaler #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_SCALE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pru_pkg::in_item_t                   in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output pru_pkg::out_item_t                  out_data,
  // apb-style configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pru_pkg::AddrW-1:0]           paddr,
  input  logic [pru_pkg::ApbW-1:0]            pwdata,
  output logic [pru_pkg::ApbW-1:0]            prdata,
  output logic                                pready
);
  import pru_pkg::*;

  // column index width, effective width and scale widths
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EW  = (CW + 1 > WidthW) ? CW + 1 : WidthW;
  localparam int SCW = $clog2(MAX_SCALE + 1);
  localparam int ES  = (SCW > ScaleW) ? SCW : ScaleW;

  // configuration registers
  logic [WidthW-1:0] sw_r, sw_nxt;
  logic [ScaleW-1:0] sf_r, sf_nxt;
  logic              cfg_wr;
  logic              reg_idx;

  // row assembly state
  logic [CW-1:0] wc_r, wc_nxt;
  logic [CW-1:0] rc_r, rc_nxt;
  logic          rr_r, rr_nxt;

  // accepted-item stage, waits on the line store read
  logic   s1_valid_r, s1_valid_nxt;
  logic   s1_replay_r;
  logic   s1_ends_r;
  logic   s1_err_r;
  pixel_t s1_pix_r;

  logic          in_fire;
  logic [EW-1:0] sw_ext;
  logic [EW-1:0] eff_w;
  logic [ES-1:0] sf_ext;
  logic [SCW-1:0] eff_s;
  logic [1:0]    prod2;
  logic [1:0]    pad_cnt;
  logic [CW-1:0] col_wr, col_rd;
  logic          wr_ends, rd_ends;
  logic          cur_ends, cur_err;

  logic          mem_we, mem_re;
  pixel_t        in_pix;
  pixel_t        rd_pix;

  job_t          job;
  logic          job_ready;

  // apb writes in the access phase, always ready
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      REG_SOURCE_WIDTH: prdata = ApbW'(sw_r);
      REG_SCALE_FACTOR: prdata = ApbW'(sf_r);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    sw_nxt = sw_r;
    sf_nxt = sf_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_SOURCE_WIDTH: sw_nxt = pwdata[WidthW-1:0];
        REG_SCALE_FACTOR: sf_nxt = pwdata[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers into the supported range
  assign sw_ext = EW'(sw_r);
  assign sf_ext = ES'(sf_r);

  always_comb begin
    if (sw_r == '0) begin
      eff_w = EW'(1);
    end else if (sw_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = sw_ext;
    end
  end

  always_comb begin
    if (sf_r == '0) begin
      eff_s = SCW'(1);
    end else if (sf_ext > ES'(MAX_SCALE)) begin
      eff_s = SCW'(MAX_SCALE);
    end else begin
      eff_s = SCW'(sf_ext);
    end
  end

  // padding to a multiple of four only needs the low two bits of width and scale
  assign prod2   = 2'(eff_w[1:0] * 2'(eff_s));
  assign pad_cnt = 2'(2'd0 - prod2);

  // column pointers wrap if they ever reach the width
  assign col_wr  = (EW'(wc_r) >= eff_w) ? '0 : wc_r;
  assign col_rd  = (EW'(rc_r) >= eff_w) ? '0 : rc_r;
  assign wr_ends = (EW'(col_wr) + EW'(1)) >= eff_w;
  assign rd_ends = (EW'(col_rd) + EW'(1)) >= eff_w;

  assign in_ready = !s1_valid_r || job_ready;
  assign in_fire  = in_valid && in_ready;

  assign in_pix.red   = in_data.red;
  assign in_pix.green = in_data.green;
  assign in_pix.blue  = in_data.blue;

  assign cur_err  = (in_data.kind == KIND_REPLAY) && !rr_r;
  assign cur_ends = (in_data.kind == KIND_SOURCE) ? wr_ends : (rd_ends && rr_r);

  // row assembly: source pixels go into the store, replays walk the stored row
  always_comb begin
    wc_nxt = wc_r;
    rc_nxt = rc_r;
    rr_nxt = rr_r;
    mem_we = 1'b0;
    mem_re = 1'b0;
    if (cfg_wr) begin
      // any register write restarts row assembly
      wc_nxt = '0;
      rc_nxt = '0;
      rr_nxt = 1'b0;
    end else if (in_fire) begin
      case (in_data.kind)
        KIND_SOURCE: begin
          mem_we = 1'b1;
          if (col_wr == '0) begin
            rr_nxt = 1'b0;
          end
          if (wr_ends) begin
            wc_nxt = '0;
            rc_nxt = '0;
            rr_nxt = 1'b1;
          end else begin
            wc_nxt = col_wr + CW'(1);
          end
        end
        KIND_REPLAY: begin
          if (rr_r) begin
            mem_re = 1'b1;
            rc_nxt = rd_ends ? '0 : col_rd + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign s1_valid_nxt = in_fire ? 1'b1 : (job_ready ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r       <= WidthW'(1);
      sf_r       <= ScaleW'(1);
      wc_r       <= '0;
      rc_r       <= '0;
      rr_r       <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      sw_r       <= sw_nxt;
      sf_r       <= sf_nxt;
      wc_r       <= wc_nxt;
      rc_r       <= rc_nxt;
      rr_r       <= rr_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // item payload held while the store read completes
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_replay_r <= (in_data.kind == KIND_REPLAY);
      s1_ends_r   <= cur_ends;
      s1_err_r    <= cur_err;
      s1_pix_r    <= in_pix;
    end
  end

  // store read data stays put until the next replay, so a stalled item keeps it
  pru_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (col_wr),
    .wdata (in_pix),
    .re    (mem_re),
    .raddr (col_rd),
    .rdata (rd_pix)
  );

  always_comb begin
    job.ends = s1_ends_r;
    job.err  = s1_err_r;
    if (s1_err_r) begin
      job.pixel = '0;
    end else if (s1_replay_r) begin
      job.pixel = rd_pix;
    end else begin
      job.pixel = s1_pix_r;
    end
  end

  // beat generator doubles as the output register
  pru_emitter #(
    .MAX_SCALE (MAX_SCALE),
    .SCW       (SCW)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (s1_valid_r),
    .job_ready (job_ready),
    .job       (job),
    .scale     (eff_s),
    .pad       (pad_cnt),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### test/pixel_replicating_upscaler_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the pixel replicating upscaler
module pixel_replicating_upscaler_tb;
  import pru_pkg::*;

  localparam int MaxWidth   = 4096;
  localparam int MaxScale   = 16;
  // cycles with no beat on either channel before the run is abandoned
  localparam int QuietLimit = 2000;
  // settle time after the last expected beat
  localparam int TailCycles = 8;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [AddrW-1:0]    paddr     = '0;
  logic [ApbW-1:0]     pwdata    = '0;
  logic [ApbW-1:0]     prdata;
  logic                pready;

  // own copy of the block state, kept in step with accepted beats
  pixel_t              row_copy [MaxWidth];
  int unsigned         store_col     = 0;
  int unsigned         replay_col    = 0;
  bit                  row_held      = 1'b0;
  logic [WidthW-1:0]   width_setting = 1;
  logic [ScaleW-1:0]   scale_setting = 1;

  // output pixels still owed by the block, oldest first
  out_item_t           pending_pixels [$];

  int                  mismatch_count = 0;
  int                  quiet_cycles   = 0;
  int                  gap_pct        = 0;
  int                  stall_pct      = 0;

  pixel_replicating_upscaler #(
    .MAX_WIDTH(MaxWidth),
    .MAX_SCALE(MaxScale)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // out-of-range register values saturate to the legal range
  function automatic int unsigned active_width();
    if (width_setting == 0) return 1;
    if (width_setting > MaxWidth) return MaxWidth;
    return 32'(width_setting);
  endfunction

  function automatic int unsigned active_scale();
    if (scale_setting == 0) return 1;
    if (scale_setting > MaxScale) return MaxScale;
    return 32'(scale_setting);
  endfunction

  // one pixel replicated scale times; at a row end, zero pixels follow until
  // the output row length is a multiple of four
  function automatic void push_copies(pixel_t px, bit ends);
    int unsigned s;
    int unsigned pad;
    int unsigned total;
    out_item_t   b;
    s   = active_scale();
    pad = 0;
    if (ends) pad = (4 - ((active_width() * s) & 3)) & 3;
    total = s + pad;
    for (int unsigned n = 0; n < total; n++) begin
      b = '0;
      if (n < s) begin
        b.out_blue  = px.blue;
        b.out_green = px.green;
        b.out_red   = px.red;
      end else begin
        b.is_padding = 1'b1;
      end
      b.last    = (n == total - 1);
      b.row_end = b.last && ends;
      pending_pixels.push_back(b);
    end
  endfunction

  function automatic void upscale_item(in_item_t it);
    int unsigned w;
    pixel_t      px;
    bit          ends;
    out_item_t   err_beat;
    w = active_width();
    if (it.kind == KIND_SOURCE) begin
      if (store_col >= w) store_col = 0;
      // first pixel of a new row: the old row can no longer be replayed
      if (store_col == 0) row_held = 1'b0;
      px.red   = it.red;
      px.green = it.green;
      px.blue  = it.blue;
      row_copy[store_col] = px;
      ends = (store_col + 1 >= w);
      if (ends) begin
        store_col  = 0;
        replay_col = 0;
        row_held   = 1'b1;
      end else begin
        store_col++;
      end
      push_copies(px, ends);
    end else if (!row_held) begin
      // replay with no complete row: a single error beat, state untouched
      err_beat       = '0;
      err_beat.error = 1'b1;
      err_beat.last  = 1'b1;
      pending_pixels.push_back(err_beat);
    end else begin
      if (replay_col >= w) replay_col = 0;
      px   = row_copy[replay_col];
      ends = (replay_col + 1 >= w);
      // replays wrap round the stored row for as long as they keep coming
      replay_col = ends ? 0 : replay_col + 1;
      push_copies(px, ends);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  function automatic string beat_text(out_item_t b);
    return $sformatf("b=%02h g=%02h r=%02h pad=%0b end=%0b err=%0b last=%0b",
                     b.out_blue, b.out_green, b.out_red, b.is_padding, b.row_end,
                     b.error, b.last);
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // every accepted result beat is held against the oldest owed pixel
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch($sformatf("beat with nothing owed: %s", beat_text(out_data)));
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.out_blue !== want.out_blue || out_data.out_green !== want.out_green ||
            out_data.out_red !== want.out_red || out_data.is_padding !== want.is_padding ||
            out_data.row_end !== want.row_end || out_data.error !== want.error ||
            out_data.last !== want.last)
          flag_mismatch($sformatf("expected %s, got %s", beat_text(want),
                                  beat_text(out_data)));
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) out_ready = ($urandom_range(0, 99) >= stall_pct);

  // watchdog: any beat on either channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("pixel_replicating_upscaler_tb: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one input beat; valid is left high so the next call can follow back to back
  task automatic send_item(logic kind, logic [23:0] bgr);
    while ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_data  = in_item_t'($urandom);
      @(posedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = {kind, bgr};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    upscale_item(in_data);
  endtask

  // stop sending and wait for every owed pixel to come out
  task automatic finish_burst();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // setup then access phase; pready is tied high so the write lands at once
  task automatic cfg_write(logic idx, logic [ApbW-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_SOURCE_WIDTH: width_setting = value[WidthW-1:0];
      REG_SCALE_FACTOR: scale_setting = value[ScaleW-1:0];
      default: ;
    endcase
    // any register write restarts row assembly
    store_col  = 0;
    replay_col = 0;
    row_held   = 1'b0;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic cfg_read_check(logic idx, logic [ApbW-1:0] want);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== want)
      flag_mismatch($sformatf("register %0d read %0h, expected %0h", idx, prdata, want));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_shape(int unsigned width, int unsigned scale);
    finish_burst();
    cfg_write(REG_SOURCE_WIDTH, width);
    cfg_write(REG_SCALE_FACTOR, scale);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // defaults after reset: one-pixel rows at scale one, so three pad pixels
  task automatic test_reset_state();
    cfg_read_check(REG_SOURCE_WIDTH, ApbW'(width_setting));
    cfg_read_check(REG_SCALE_FACTOR, ApbW'(scale_setting));
    send_item(KIND_REPLAY, 24'h123456);
    send_item(KIND_SOURCE, 24'h0F1E2D);
    send_item(KIND_REPLAY, 24'hFFFFFF);
  endtask

  // all-zero and all-one bytes plus a mixed pattern, then replays that wrap
  task automatic test_pixel_extremes();
    set_shape(3, 3);
    send_item(KIND_SOURCE, 24'h000000);
    send_item(KIND_SOURCE, 24'hFFFFFF);
    send_item(KIND_SOURCE, 24'hA55AC3);
    repeat (4) send_item(KIND_REPLAY, 24'($urandom));
  endtask

  // zero and oversized register values saturate
  task automatic test_register_limits();
    set_shape(0, 0);
    send_item(KIND_SOURCE, 24'h5A5A5A);
    send_item(KIND_REPLAY, 24'h000000);
    set_shape(8191, 31);
    cfg_read_check(REG_SOURCE_WIDTH, ApbW'(width_setting));
    cfg_read_check(REG_SCALE_FACTOR, ApbW'(scale_setting));
    send_item(KIND_SOURCE, 24'h81C3E7);
    send_item(KIND_SOURCE, 24'h7E3C18);
    // row far from complete, so the replay is refused
    send_item(KIND_REPLAY, 24'h000000);
    set_shape(MaxWidth, MaxScale);
    send_item(KIND_SOURCE, 24'hC0FFEE);
  endtask

  // a new row drops the old one, and a register write drops a part row
  task automatic test_row_restart();
    set_shape(2, 2);
    send_item(KIND_SOURCE, 24'h102030);
    send_item(KIND_SOURCE, 24'h405060);
    send_item(KIND_REPLAY, 24'h000000);
    send_item(KIND_SOURCE, 24'h708090);
    send_item(KIND_REPLAY, 24'h000000);
    send_item(KIND_SOURCE, 24'hA0B0C0);
    send_item(KIND_REPLAY, 24'h000000);
    send_item(KIND_SOURCE, 24'hD0E0F0);
    finish_burst();
    cfg_write(REG_SCALE_FACTOR, 2);
    send_item(KIND_REPLAY, 24'h000000);
  endtask

  // mostly whole rows followed by replays, some loose beats in between;
  // hold_off pauses the sender once, midway, until the block has drained
  task automatic run_random_phase(int gap, int stall, int items, bit hold_off);
    int          sent;
    int unsigned w;
    int unsigned reps;
    int unsigned pick_w;
    int unsigned pick_s;
    int          roll;
    gap_pct   = gap;
    stall_pct = stall;
    sent      = 0;
    while (sent < items) begin
      if ($urandom_range(0, 3) == 0) begin
        pick_w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 7);
        roll   = $urandom_range(0, 19);
        if (roll == 0) pick_s = 0;
        else if (roll == 1) pick_s = $urandom_range(MaxScale + 1, 31);
        else pick_s = $urandom_range(1, MaxScale);
        set_shape(pick_w, pick_s);
      end
      w = active_width();
      if ($urandom_range(0, 99) < 80) begin
        repeat (w) send_item(KIND_SOURCE, 24'($urandom));
        reps = w * $urandom_range(1, 3);
        // sometimes stop partway through a row
        if ($urandom_range(0, 3) == 0) reps += $urandom_range(0, w - 1);
        repeat (reps) send_item(KIND_REPLAY, 24'($urandom));
        sent += w + reps;
      end else begin
        reps = $urandom_range(1, 5);
        repeat (reps) send_item(1'($urandom_range(0, 1)), 24'($urandom));
        sent += reps;
      end
      if (hold_off && sent >= items / 2) begin
        finish_burst();
        hold_off = 1'b0;
      end
    end
    finish_burst();
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_pixel_extremes();
    test_register_limits();
    test_row_restart();

    run_random_phase(0, 0, 44, 1'b0);
    run_random_phase(64, 0, 44, 1'b0);
    run_random_phase(0, 64, 44, 1'b0);
    run_random_phase(35, 35, 44, 1'b1);

    finish_burst();
    // anything arriving now is a beat nobody asked for
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels.size() == 0)
      $display("pixel_replicating_upscaler_tb: done, clean");
    else
      $display("pixel_replicating_upscaler_tb: done, errors");
    $finish;
  end

endmodule
